// File: hdl/hbs_pkg.sv
package hbs_pkg;

    localparam int POS_W       = 21;
    localparam int ADDR_W      = 15;
    localparam int DATA_W      = 16;
    localparam int HEIGHT_W    = 20;
    localparam int TILES_W     = 7;
    localparam int FIRST_W     = 15;
    localparam int CFG_INDEX_W = 2;

    // The tile index of a sample inside the map is below 127 * 127.
    localparam int TILE_SUM_W  = 14;

    typedef enum logic [1:0] {
        CMD_WR_VERTEX = 2'd0,
        CMD_WR_TILE   = 2'd1,
        CMD_SAMPLE    = 2'd2
    } cmd_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TILES_WIDE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TILES_HIGH = 2'd2;

endpackage

// File: hdl/hbs_ram.sv
module hbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/heightfield_bilinear_sampler.sv
// Terrain height sampler. Vertex heights (command 0) and the first corner vertex of each tile
// (command 1) are loaded through the input channel and take effect in transfer order; both
// stores are undefined until written and are never cleared. A sample (command 2) returns one
// result transfer with the bilinear height in 1/16 units, or zero with in_bounds clear when the
// block is disabled or the position is not strictly inside the map; writes return nothing. The
// block accepts one transfer every clock cycle while the output is not stalled. Its pipeline
// holds a tile index multiply, a reciprocal-multiply modulo, the tile store read, a second
// modulo for the vertex index, four parallel vertex store reads and two rounds of multiply and
// add. A stalled output freezes the whole pipeline.
module heightfield_bilinear_sampler #(
    parameter int TILE_BITS    = 7,
    parameter int FRAC_BITS    = 8,
    parameter int TILE_DEPTH   = 4096,
    parameter int VERTEX_DEPTH = 32768
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [hbs_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [hbs_pkg::TILES_W-1:0]          cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_cmd,
    input  logic [hbs_pkg::ADDR_W-1:0]           s_addr,
    input  logic signed [hbs_pkg::DATA_W-1:0]    s_wdata,
    input  logic [hbs_pkg::POS_W-1:0]            s_x_pos,
    input  logic [hbs_pkg::POS_W-1:0]            s_y_pos,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [hbs_pkg::HEIGHT_W-1:0]  m_terrain_height,
    output logic                                 m_in_bounds
);

    localparam int S       = TILE_BITS + FRAC_BITS;
    localparam int CMP_W   = (S + hbs_pkg::TILES_W > hbs_pkg::POS_W) ?
                             S + hbs_pkg::TILES_W : hbs_pkg::POS_W;
    localparam int TA_W    = $clog2(TILE_DEPTH);
    localparam int VA_W    = $clog2(VERTEX_DEPTH);
    localparam int TS_W    = hbs_pkg::TILE_SUM_W;
    localparam int FV_W    = hbs_pkg::FIRST_W;
    localparam int T_SH    = TS_W + TA_W;
    localparam int V_SH    = FV_W + VA_W;
    localparam int TP_W    = TS_W + TS_W + 2;
    localparam int VP_W    = FV_W + FV_W + 2;
    localparam longint T_REC = ((longint'(1) << T_SH) + TILE_DEPTH - 1) / TILE_DEPTH;
    localparam longint V_REC = ((longint'(1) << V_SH) + VERTEX_DEPTH - 1) / VERTEX_DEPTH;
    localparam int LR_W    = hbs_pkg::DATA_W + S;
    localparam int SUM_W   = hbs_pkg::DATA_W + 2 * S;
    localparam int Q_SH    = 2 * S - 4;
    localparam int HW      = hbs_pkg::HEIGHT_W;
    localparam int NSTG    = 11;

    localparam logic [TS_W-1:0] T_DEP_N = TS_W'(TILE_DEPTH);
    localparam logic [FV_W-1:0] V_DEP_N = FV_W'(VERTEX_DEPTH);
    localparam logic [VA_W:0]   V_DEP_W = (VA_W + 1)'(VERTEX_DEPTH);
    localparam logic [S:0]      W_N     = (S + 1)'(longint'(1) << S);

    typedef struct packed {
        hbs_pkg::cmd_t                 cmd;
        logic [hbs_pkg::ADDR_W-1:0]    addr;
        logic [hbs_pkg::DATA_W-1:0]    wdata;
        logic [S-1:0]                  dx;
        logic [S-1:0]                  dy;
        logic                          in_map;
    } ctl_t;

    logic                          enable_reg;
    logic [hbs_pkg::TILES_W-1:0]   tiles_wide_reg;
    logic [hbs_pkg::TILES_W-1:0]   tiles_high_reg;

    logic                          advance;
    logic [NSTG:1]                 valid_reg;
    ctl_t                          ctl_reg [1:NSTG];
    ctl_t                          ctl_next;

    logic [CMP_W-1:0]              x_ext, y_ext, x_lim, y_lim, x_sh, y_sh;
    logic [hbs_pkg::TILES_W-1:0]   ix_reg, iy_reg;
    logic [TS_W-1:0]               tsum_reg, tsum3_reg, tquot;
    logic [TP_W-1:0]               tprod_reg;
    logic [TA_W-1:0]               tile_reg;
    logic                          tile_wr_en;
    logic [FV_W-1:0]               tile_rd_data, first6_reg, vquot;
    logic [VP_W-1:0]               vprod_reg;
    logic [VA_W-1:0]               vbase_reg;
    logic                          vertex_wr_en;
    logic [VA_W-1:0]               corner_addr [4];
    logic [hbs_pkg::DATA_W-1:0]    corner_raw [4];
    logic [hbs_pkg::DATA_W-1:0]    z [4];
    logic [S:0]                    ndy, ndx;
    logic [LR_W-1:0]               a_reg [4];
    logic [LR_W-1:0]               left_reg, right_reg;
    logic [SUM_W-1:0]              bl_reg, br_reg, sum;
    logic [HW-1:0]                 qh;

    logic                          m_valid_reg;
    logic signed [HW-1:0]          m_terrain_height_reg;
    logic                          m_in_bounds_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b0;
            tiles_wide_reg <= '0;
            tiles_high_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                hbs_pkg::CFG_ENABLE:     enable_reg     <= cfg_wdata[0];
                hbs_pkg::CFG_TILES_WIDE: tiles_wide_reg <= cfg_wdata;
                hbs_pkg::CFG_TILES_HIGH: tiles_high_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    assign x_ext = CMP_W'(s_x_pos);
    assign y_ext = CMP_W'(s_y_pos);
    assign x_lim = CMP_W'(tiles_wide_reg) << S;
    assign y_lim = CMP_W'(tiles_high_reg) << S;
    assign x_sh  = x_ext >> S;
    assign y_sh  = y_ext >> S;

    always_comb begin
        ctl_next.cmd    = hbs_pkg::cmd_t'(s_cmd);
        ctl_next.addr   = s_addr;
        ctl_next.wdata  = s_wdata;
        ctl_next.dx     = x_ext[S-1:0];
        ctl_next.dy     = y_ext[S-1:0];
        ctl_next.in_map = enable_reg && (s_x_pos != '0) && (s_y_pos != '0)
                          && (x_ext < x_lim) && (y_ext < y_lim);
    end

    assign tquot = TS_W'(tprod_reg >> T_SH);
    assign vquot = FV_W'(vprod_reg >> V_SH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg   <= {valid_reg[NSTG-1:1], s_valid};
            m_valid_reg <= valid_reg[NSTG] && (ctl_reg[NSTG].cmd == hbs_pkg::CMD_SAMPLE);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ctl_reg[1] <= ctl_next;
            for (int i = 2; i <= NSTG; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
            ix_reg     <= x_sh[hbs_pkg::TILES_W-1:0];
            iy_reg     <= y_sh[hbs_pkg::TILES_W-1:0];
            tsum_reg   <= TS_W'(iy_reg) * TS_W'(tiles_wide_reg) + TS_W'(ix_reg);
            tprod_reg  <= TP_W'(tsum_reg) * TP_W'(T_REC);
            tsum3_reg  <= tsum_reg;
            tile_reg   <= TA_W'(tsum3_reg - tquot * T_DEP_N);
            vprod_reg  <= VP_W'(tile_rd_data) * VP_W'(V_REC);
            first6_reg <= tile_rd_data;
            vbase_reg  <= VA_W'(first6_reg - vquot * V_DEP_N);
            a_reg[0]   <= LR_W'(z[0]) * LR_W'(ndy);
            a_reg[1]   <= LR_W'(z[1]) * LR_W'(ndy);
            a_reg[2]   <= LR_W'(z[2]) * LR_W'(ctl_reg[8].dy);
            a_reg[3]   <= LR_W'(z[3]) * LR_W'(ctl_reg[8].dy);
            left_reg   <= a_reg[0] + a_reg[3];
            right_reg  <= a_reg[1] + a_reg[2];
            bl_reg     <= SUM_W'(left_reg) * SUM_W'(ndx);
            br_reg     <= SUM_W'(right_reg) * SUM_W'(ctl_reg[10].dx);
            m_terrain_height_reg <= ctl_reg[NSTG].in_map ?
                                    signed'({~qh[HW-1], qh[HW-2:0]}) : '0;
            m_in_bounds_reg <= ctl_reg[NSTG].in_map;
        end
    end

    assign tile_wr_en = advance && valid_reg[4] && (ctl_reg[4].cmd == hbs_pkg::CMD_WR_TILE)
                        && (int'(ctl_reg[4].addr) < TILE_DEPTH);

    hbs_ram #(
        .WIDTH (FV_W),
        .DEPTH (TILE_DEPTH)
    ) u_tile_ram (
        .aclk    (aclk),
        .wr_en   (tile_wr_en),
        .wr_addr (TA_W'(ctl_reg[4].addr)),
        .wr_data (ctl_reg[4].wdata[FV_W-1:0]),
        .rd_en   (advance),
        .rd_addr (tile_reg),
        .rd_data (tile_rd_data)
    );

    assign vertex_wr_en = advance && valid_reg[7]
                          && (ctl_reg[7].cmd == hbs_pkg::CMD_WR_VERTEX)
                          && (int'(ctl_reg[7].addr) < VERTEX_DEPTH);

    for (genvar k = 0; k < 4; k++) begin : g_corner
        logic [VA_W:0] csum;

        assign csum = (VA_W + 1)'(vbase_reg) + (VA_W + 1)'(k);
        assign corner_addr[k] = (csum >= V_DEP_W) ? VA_W'(csum - V_DEP_W) : VA_W'(csum);
        assign z[k] = corner_raw[k] ^ {1'b1, {(hbs_pkg::DATA_W - 1){1'b0}}};

        hbs_ram #(
            .WIDTH (hbs_pkg::DATA_W),
            .DEPTH (VERTEX_DEPTH)
        ) u_vertex_ram (
            .aclk    (aclk),
            .wr_en   (vertex_wr_en),
            .wr_addr (VA_W'(ctl_reg[7].addr)),
            .wr_data (ctl_reg[7].wdata),
            .rd_en   (advance),
            .rd_addr (corner_addr[k]),
            .rd_data (corner_raw[k])
        );
    end

    assign ndy = W_N - (S + 1)'(ctl_reg[8].dy);
    assign ndx = W_N - (S + 1)'(ctl_reg[10].dx);
    assign sum = bl_reg + br_reg;
    assign qh  = HW'(sum >> Q_SH);

    assign m_valid          = m_valid_reg;
    assign m_terrain_height = m_terrain_height_reg;
    assign m_in_bounds      = m_in_bounds_reg;

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && valid_reg[NSTG] && (ctl_reg[NSTG].cmd != hbs_pkg::CMD_SAMPLE))
        |=> !m_valid_reg)
        else $error("A write command produced a result transfer.");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(valid_reg))
        else $error("The pipeline moved while the output was stalled.");

    a_corner_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[7] && (ctl_reg[7].cmd == hbs_pkg::CMD_SAMPLE) && ctl_reg[7].in_map)
        |-> ((VA_W + 1)'(corner_addr[0]) < V_DEP_W)
         && ((VA_W + 1)'(corner_addr[1]) < V_DEP_W)
         && ((VA_W + 1)'(corner_addr[2]) < V_DEP_W)
         && ((VA_W + 1)'(corner_addr[3]) < V_DEP_W))
        else $error("A corner vertex index escaped the vertex store.");

    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_in_bounds_reg) |-> (m_terrain_height_reg == '0))
        else $error("An out-of-bounds sample returned a non-zero height.");

endmodule

// File: dv/height_sample_checker.sv
`timescale 1ns / 100ps

module height_sample_checker #(
    parameter int TILE_BITS    = 7,
    parameter int FRAC_BITS    = 8,
    parameter int TILE_DEPTH   = 4096,
    parameter int VERTEX_DEPTH = 32768
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [hbs_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [hbs_pkg::TILES_W-1:0]          cfg_wdata,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic [1:0]                           s_cmd,
    input  logic [hbs_pkg::ADDR_W-1:0]           s_addr,
    input  logic signed [hbs_pkg::DATA_W-1:0]    s_wdata,
    input  logic [hbs_pkg::POS_W-1:0]            s_x_pos,
    input  logic [hbs_pkg::POS_W-1:0]            s_y_pos,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic signed [hbs_pkg::HEIGHT_W-1:0]  m_terrain_height,
    input  logic                                 m_in_bounds,
    output int                                   heights_pending,
    output int                                   mismatch_count
);

    localparam int SHIFT = TILE_BITS + FRAC_BITS;
    localparam logic [63:0] SPAN = 64'd1 << SHIFT;

    typedef struct packed {
        logic signed [hbs_pkg::HEIGHT_W-1:0] height;
        logic                                in_bounds;
    } height_result_t;

    logic [hbs_pkg::DATA_W-1:0]  vertex_mem [VERTEX_DEPTH];
    logic [hbs_pkg::FIRST_W-1:0] tile_mem [TILE_DEPTH];
    logic                        map_enable;
    logic [hbs_pkg::TILES_W-1:0] map_wide;
    logic [hbs_pkg::TILES_W-1:0] map_high;
    height_result_t              expected_heights [$];

    // Corner heights are blended as offset values, with the sign bit flipped.
    function automatic logic [63:0] corner_level(logic [hbs_pkg::FIRST_W-1:0] first, int k);
        logic [hbs_pkg::DATA_W-1:0] h;
        h = vertex_mem[(int'(first) + k) % VERTEX_DEPTH];
        return {48'd0, h ^ 16'h8000};
    endfunction

    function automatic height_result_t predict_height(logic [hbs_pkg::POS_W-1:0] x,
                                                      logic [hbs_pkg::POS_W-1:0] y);
        height_result_t              res;
        logic [63:0]                 px, py, span_x, span_y, ix, iy, dx, dy;
        logic [63:0]                 near_x, far_x, blend, level;
        int                          tile;
        logic [hbs_pkg::FIRST_W-1:0] first;
        res = '0;
        px = x;
        py = y;
        span_x = map_wide;
        span_y = map_high;
        if (!map_enable || px == 0 || py == 0 || px >= (span_x << SHIFT)
                || py >= (span_y << SHIFT)) begin
            return res;
        end
        ix = px >> SHIFT;
        iy = py >> SHIFT;
        dx = px & (SPAN - 1);
        dy = py & (SPAN - 1);
        tile = int'((iy * span_x + ix) % TILE_DEPTH);
        first = tile_mem[tile];
        near_x = corner_level(first, 0) * (SPAN - dy) + corner_level(first, 3) * dy;
        far_x = corner_level(first, 1) * (SPAN - dy) + corner_level(first, 2) * dy;
        blend = near_x * (SPAN - dx) + far_x * dx;
        level = (blend >> (2 * SHIFT - 4)) - (64'd1 << (hbs_pkg::HEIGHT_W - 1));
        res.height = level[hbs_pkg::HEIGHT_W-1:0];
        res.in_bounds = 1'b1;
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        height_result_t got;
        height_result_t want;
        if (!aresetn) begin
            map_enable = 1'b0;
            map_wide = '0;
            map_high = '0;
            expected_heights.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    hbs_pkg::CFG_ENABLE:     map_enable = cfg_wdata[0];
                    hbs_pkg::CFG_TILES_WIDE: map_wide = cfg_wdata;
                    hbs_pkg::CFG_TILES_HIGH: map_high = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_cmd)
                    hbs_pkg::CMD_WR_VERTEX: begin
                        if (s_addr < VERTEX_DEPTH) vertex_mem[s_addr] = s_wdata;
                    end
                    hbs_pkg::CMD_WR_TILE: begin
                        if (s_addr < TILE_DEPTH) begin
                            tile_mem[s_addr] = s_wdata[hbs_pkg::FIRST_W-1:0];
                        end
                    end
                    hbs_pkg::CMD_SAMPLE: begin
                        expected_heights.push_back(predict_height(s_x_pos, s_y_pos));
                    end
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got.height = m_terrain_height;
                got.in_bounds = m_in_bounds;
                if (expected_heights.size() == 0) begin
                    $error("result transfer with no sample waiting: height %0d, in_bounds %0b",
                           got.height, got.in_bounds);
                    mismatch_count++;
                end else begin
                    want = expected_heights.pop_front();
                    if (got.height !== want.height) begin
                        $error("height: expected %0d, actual %0d", want.height, got.height);
                        mismatch_count++;
                    end
                    if (got.in_bounds !== want.in_bounds) begin
                        $error("in_bounds: expected %0b, actual %0b",
                               want.in_bounds, got.in_bounds);
                        mismatch_count++;
                    end
                end
            end
        end
        heights_pending = expected_heights.size();
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int TILE_BITS      = 7;
    localparam int FRAC_BITS      = 8;
    localparam int TILE_DEPTH     = 4096;
    localparam int VERTEX_DEPTH   = 32768;
    localparam int SHIFT          = TILE_BITS + FRAC_BITS;
    localparam int SPAN           = 1 << SHIFT;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int ITEM_TARGET    = 1650;
    localparam int PHASE_ITEMS    = 150;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 cfg_wr_en;
    logic [hbs_pkg::CFG_INDEX_W-1:0]      cfg_index;
    logic [hbs_pkg::TILES_W-1:0]          cfg_wdata;
    logic                                 s_valid;
    logic                                 s_ready;
    logic [1:0]                           s_cmd;
    logic [hbs_pkg::ADDR_W-1:0]           s_addr;
    logic signed [hbs_pkg::DATA_W-1:0]    s_wdata;
    logic [hbs_pkg::POS_W-1:0]            s_x_pos;
    logic [hbs_pkg::POS_W-1:0]            s_y_pos;
    logic                                 m_valid;
    logic                                 m_ready;
    logic signed [hbs_pkg::HEIGHT_W-1:0]  m_terrain_height;
    logic                                 m_in_bounds;
    int                                   heights_pending;
    int                                   mismatch_count;

    // What has been written so far, so that no sample reads an undefined entry.
    bit                          vertex_written [VERTEX_DEPTH];
    bit                          tile_written [TILE_DEPTH];
    logic [hbs_pkg::FIRST_W-1:0] tile_base [TILE_DEPTH];
    bit                          map_on;
    int                          map_wide;
    int                          map_high;

    bit in_gaps   = 1'b1;
    bit out_gaps  = 1'b1;
    bit churn     = 1'b0;
    int hold_req  = 0;
    int quiet_cycles = 0;
    int item_count = 0;
    int ignored_count = 0;
    int sample_count = 0;
    int write_count = 0;
    int setting_count = 0;

    heightfield_bilinear_sampler #(
        .TILE_BITS(TILE_BITS),
        .FRAC_BITS(FRAC_BITS),
        .TILE_DEPTH(TILE_DEPTH),
        .VERTEX_DEPTH(VERTEX_DEPTH)
    ) i_dut (.*);

    height_sample_checker #(
        .TILE_BITS(TILE_BITS),
        .FRAC_BITS(FRAC_BITS),
        .TILE_DEPTH(TILE_DEPTH),
        .VERTEX_DEPTH(VERTEX_DEPTH)
    ) i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (out_gaps) begin
                m_ready <= ($urandom_range(99) >= 37);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no transfer for %0d cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] cmd, logic [hbs_pkg::ADDR_W-1:0] addr,
                             logic [hbs_pkg::DATA_W-1:0] wdata,
                             logic [hbs_pkg::POS_W-1:0] x, logic [hbs_pkg::POS_W-1:0] y);
        while (in_gaps && $urandom_range(99) < 37) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_addr <= addr;
        s_wdata <= wdata;
        s_x_pos <= x;
        s_y_pos <= y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (cmd == CMD_UNUSED || (cmd == hbs_pkg::CMD_WR_TILE && addr >= TILE_DEPTH)) begin
            ignored_count++;
        end else begin
            item_count++;
        end
    endtask

    task automatic drain(int settle);
        s_valid <= 1'b0;
        do @(negedge aclk); while (heights_pending != 0);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic set_map(bit en, int wide, int high);
        cfg_wr_en <= 1'b1;
        cfg_index <= hbs_pkg::CFG_ENABLE;
        cfg_wdata <= hbs_pkg::TILES_W'(en);
        @(negedge aclk);
        cfg_index <= hbs_pkg::CFG_TILES_WIDE;
        cfg_wdata <= hbs_pkg::TILES_W'(wide);
        @(negedge aclk);
        cfg_index <= hbs_pkg::CFG_TILES_HIGH;
        cfg_wdata <= hbs_pkg::TILES_W'(high);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        map_on = en;
        map_wide = wide;
        map_high = high;
        setting_count++;
    endtask

    function automatic logic [hbs_pkg::DATA_W-1:0] pick_height();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return 16'h8000;
        if (pick == 1) return 16'h7FFF;
        return hbs_pkg::DATA_W'($urandom);
    endfunction

    function automatic logic [hbs_pkg::POS_W-1:0] pick_pos(int tiles);
        int limit;
        int pick;
        limit = tiles * SPAN;
        pick = $urandom_range(19);
        if (tiles == 0 || pick == 0) return hbs_pkg::POS_W'($urandom);
        if (pick == 1) return '0;
        if (pick == 2) begin
            return (limit >= (1 << hbs_pkg::POS_W)) ? {hbs_pkg::POS_W{1'b1}}
                                                     : hbs_pkg::POS_W'(limit);
        end
        if (pick == 3) return hbs_pkg::POS_W'(limit - 1);
        if (pick == 4) return hbs_pkg::POS_W'(1);
        return hbs_pkg::POS_W'($urandom_range(limit - 1, 1));
    endfunction

    task automatic write_vertex(int v, logic [hbs_pkg::DATA_W-1:0] h);
        send_item(hbs_pkg::CMD_WR_VERTEX, hbs_pkg::ADDR_W'(v), h,
                  hbs_pkg::POS_W'($urandom), hbs_pkg::POS_W'($urandom));
        vertex_written[v] = 1'b1;
        write_count++;
    endtask

    // The top data bit of a tile write is not stored, so it is set at random.
    task automatic write_tile(int t, logic [hbs_pkg::FIRST_W-1:0] first);
        send_item(hbs_pkg::CMD_WR_TILE, hbs_pkg::ADDR_W'(t), {($urandom_range(1) == 1), first},
                  hbs_pkg::POS_W'($urandom), hbs_pkg::POS_W'($urandom));
        if (t < TILE_DEPTH) begin
            tile_written[t] = 1'b1;
            tile_base[t] = first;
        end
        write_count++;
    endtask

    task automatic prepare_tile(int tile);
        logic [hbs_pkg::FIRST_W-1:0] first;
        int                          v;
        if (!tile_written[tile] || (churn && $urandom_range(9) == 0)) begin
            if ($urandom_range(7) == 0) begin
                first = hbs_pkg::FIRST_W'(VERTEX_DEPTH - 1 - $urandom_range(2));
            end else begin
                first = hbs_pkg::FIRST_W'($urandom);
            end
            write_tile(tile, first);
        end
        for (int k = 0; k < 4; k++) begin
            v = (int'(tile_base[tile]) + k) % VERTEX_DEPTH;
            if (!vertex_written[v] || (churn && $urandom_range(3) == 0)) begin
                write_vertex(v, pick_height());
            end
        end
    endtask

    task automatic sample_at(logic [hbs_pkg::POS_W-1:0] x, logic [hbs_pkg::POS_W-1:0] y);
        if (map_on && x != 0 && y != 0 && int'(x) < map_wide * SPAN
                && int'(y) < map_high * SPAN) begin
            prepare_tile(((int'(y) >> SHIFT) * map_wide + (int'(x) >> SHIFT)) % TILE_DEPTH);
        end
        send_item(hbs_pkg::CMD_SAMPLE, hbs_pkg::ADDR_W'($urandom), hbs_pkg::DATA_W'($urandom),
                  x, y);
        sample_count++;
    endtask

    task automatic run_directed();
        send_item(CMD_UNUSED, '1, '1, '1, '1);
        sample_at(hbs_pkg::POS_W'(1), hbs_pkg::POS_W'(1));
        sample_at('1, '1);
        drain(SETTLE_CYCLES);
        set_map(1'b1, 2, 2);
        // Tile 0 starts two vertices before the end of the store, so its corners wrap.
        write_tile(0, hbs_pkg::FIRST_W'(VERTEX_DEPTH - 2));
        write_vertex(VERTEX_DEPTH - 2, 16'h8000);
        write_vertex(VERTEX_DEPTH - 1, 16'h7FFF);
        write_vertex(0, 16'h7FFF);
        write_vertex(1, 16'h8000);
        write_tile(1, hbs_pkg::FIRST_W'(100));
        for (int k = 0; k < 4; k++) write_vertex(100 + k, 16'h7FFF);
        write_tile(2, hbs_pkg::FIRST_W'(200));
        for (int k = 0; k < 4; k++) write_vertex(200 + k, 16'h8000);
        write_tile(TILE_DEPTH, '0);
        write_tile(32767, '1);
        sample_at(hbs_pkg::POS_W'(1), hbs_pkg::POS_W'(1));
        sample_at(hbs_pkg::POS_W'(SPAN - 1), hbs_pkg::POS_W'(SPAN - 1));
        sample_at(hbs_pkg::POS_W'(SPAN + SPAN / 2), hbs_pkg::POS_W'(SPAN / 2));
        sample_at(hbs_pkg::POS_W'(SPAN / 2), hbs_pkg::POS_W'(SPAN + SPAN / 2));
        sample_at(hbs_pkg::POS_W'(0), hbs_pkg::POS_W'(5));
        sample_at(hbs_pkg::POS_W'(5), hbs_pkg::POS_W'(0));
        sample_at(hbs_pkg::POS_W'(2 * SPAN), hbs_pkg::POS_W'(7));
        sample_at(hbs_pkg::POS_W'(7), hbs_pkg::POS_W'(2 * SPAN));
        sample_at(hbs_pkg::POS_W'(2 * SPAN - 1), hbs_pkg::POS_W'(2 * SPAN - 1));
    endtask

    task automatic run_phase(int n_items);
        int first_item;
        int pick;
        first_item = item_count;
        while (item_count - first_item < n_items) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                send_item(CMD_UNUSED, hbs_pkg::ADDR_W'($urandom), hbs_pkg::DATA_W'($urandom),
                          hbs_pkg::POS_W'($urandom), hbs_pkg::POS_W'($urandom));
            end else if (pick < 8) begin
                write_tile($urandom_range(32767, TILE_DEPTH), hbs_pkg::FIRST_W'($urandom));
            end else if (pick < 14) begin
                write_vertex($urandom_range(VERTEX_DEPTH - 1), pick_height());
            end else if (pick < 15) begin
                drain(1);
            end else begin
                sample_at(pick_pos(map_wide), pick_pos(map_high));
            end
        end
    endtask

    initial begin : stimulus
        int phase;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_cmd = '0;
        s_addr = '0;
        s_wdata = '0;
        s_x_pos = '0;
        s_y_pos = '0;
        map_on = 1'b0;
        map_wide = 0;
        map_high = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_directed();
        churn = 1'b1;

        phase = 0;
        while (item_count < ITEM_TARGET) begin
            drain(SETTLE_CYCLES);
            in_gaps = (phase != 0);
            out_gaps <= (phase != 0);
            case (phase)
                0: set_map(1'b1, 1, 1);
                1: set_map(1'b1, 64, 64);
                2: set_map(1'b1, 3, 2);
                3: set_map(1'b0, 5, 5);
                4: set_map(1'b1, 64, 1);
                5: set_map(1'b1, 1, 64);
                6: set_map(1'b1, 0, 7);
                7: set_map(1'b1, 5, 7);
                default: set_map($urandom_range(7) != 0, $urandom_range(64), $urandom_range(64));
            endcase
            if (phase == 2) begin
                // The result side holds off while samples keep coming, so the pipeline fills.
                in_gaps = 1'b0;
                hold_req <= hold_req + 1;
                repeat (80) sample_at(pick_pos(map_wide), pick_pos(map_high));
                in_gaps = 1'b1;
            end
            run_phase(PHASE_ITEMS);
            phase++;
        end

        drain(SETTLE_CYCLES);
        $display("Covered %0d samples and %0d store writes, plus %0d ignored transfers.",
                 sample_count, write_count, ignored_count);
        $display("Covered %0d map settings, a long result hold-off and idle gaps on both sides.",
                 setting_count);
        if (mismatch_count == 0 && heights_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: heightfield_bilinear_sampler.f
hdl/hbs_pkg.sv
hdl/hbs_ram.sv
hdl/heightfield_bilinear_sampler.sv
dv/height_sample_checker.sv
dv/testbench.sv
